### rtl/core/adcrr_pkg.sv
// ============================================================================
// adcrr_pkg
// Shared types and constants for the ADC round-robin scan sequencer: command
// codes, field widths, request/response payloads and the sample store port.
// ============================================================================
package adcrr_pkg;

    // Field widths
    localparam int CHAN_W    = 4;
    localparam int SAMPLE_W  = 16;
    localparam int CMD_W     = 2;
    localparam int MAX_CHANS = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DONE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Command transaction payload
    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [SAMPLE_W-1:0] sample_value;
        logic [CHAN_W-1:0]   read_channel;
    } adcrr_cmd_t;

    // Response transaction payload
    typedef struct packed {
        logic                start_conversion;
        logic [CHAN_W-1:0]   convert_channel;
        logic [SAMPLE_W-1:0] read_data;
    } adcrr_rsp_t;

    // Sample store write port
    typedef struct packed {
        logic                en;
        logic [CHAN_W-1:0]   addr;
        logic [SAMPLE_W-1:0] data;
    } adcrr_wr_t;

endpackage

### rtl/core/adcrr_next_sel.sv
// ============================================================================
// adcrr_next_sel
// Round-robin channel picker: finds the first enabled channel at or after a
// starting channel, wrapping at the scan count.
// ============================================================================
module adcrr_next_sel
    import adcrr_pkg::*;
#(
    parameter int SCAN_COUNT = 16
)
(
    input  logic [MAX_CHANS-1:0] mask,
    input  logic [CHAN_W-1:0]    from,
    output logic                 found,
    output logic [CHAN_W-1:0]    chan
);

    logic [CHAN_W:0] pos;

    // Scan from the highest offset down so the lowest offset wins
    always_comb
    begin
        found = 1'b0;
        chan  = '0;
        pos   = '0;
        for (int i = SCAN_COUNT - 1; i >= 0; i--)
        begin
            pos = {1'b0, from} + (CHAN_W+1)'(i);
            if (pos >= (CHAN_W+1)'(SCAN_COUNT))
            begin
                pos = pos - (CHAN_W+1)'(SCAN_COUNT);
            end
            if (mask[pos[CHAN_W-1:0]])
            begin
                found = 1'b1;
                chan  = pos[CHAN_W-1:0];
            end
        end
    end

endmodule

### rtl/core/adcrr_sample_store.sv
// ============================================================================
// adcrr_sample_store
// Per-channel sample registers, cleared at reset, one write port and one
// combinational read port.
// ============================================================================
module adcrr_sample_store
    import adcrr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  adcrr_wr_t           wr,
    input  logic [CHAN_W-1:0]   rd_addr,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] store_reg [MAX_CHANS];

    // Clear on reset, write one entry per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            store_reg[wr.addr] <= wr.data;
        end
    end

    // Read the requested channel
    assign rd_data = store_reg[rd_addr];

endmodule

### rtl/core/adc_round_robin_scan_sequencer.sv
// ============================================================================
// adc_round_robin_scan_sequencer
// Steps an ADC through the enabled channels in round-robin order, keeps the
// last sample of each channel and answers channel reads.
//
//   channel | dir | handshake            | payload
//   cmd     | in  | cmd_valid/cmd_ready  | cmd_data (adcrr_cmd_t)
//   rsp     | out | rsp_valid/rsp_ready  | rsp_data (adcrr_rsp_t)
//   cfg     | in  | cfg_we               | cfg_wdata (channel enable mask)
//
// One transaction per cycle while rsp_ready does not stall the response; a response
// passes through the input register, then the response register.
// Channel choice is a single round-robin priority encode over the mask.
// Reset clears the mask, the current channel and all stored samples.
// A stalled response holds the response register; the input register still
// takes a command while it is empty, or the response register is free or being drained.
// ============================================================================
module adc_round_robin_scan_sequencer
    import adcrr_pkg::*;
#(
    parameter int NUM_CHANNELS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  adcrr_cmd_t           cmd_data,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output adcrr_rsp_t           rsp_data,
    input  logic                 cfg_we,
    input  logic [SAMPLE_W-1:0]  cfg_wdata
);

    localparam int SCAN_COUNT = (NUM_CHANNELS < MAX_CHANS) ? NUM_CHANNELS : MAX_CHANS;
    localparam logic [MAX_CHANS:0] LIM_WIDE = ((MAX_CHANS+1)'(1) << SCAN_COUNT)
                                              - (MAX_CHANS+1)'(1);
    localparam logic [MAX_CHANS-1:0] SCAN_LIM = LIM_WIDE[MAX_CHANS-1:0];
    localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(SCAN_COUNT - 1);

    logic [MAX_CHANS-1:0] mask_reg;
    logic [CHAN_W-1:0]    cur_reg;
    logic [CHAN_W-1:0]    cur_next;
    logic                 s1_valid_reg;
    adcrr_cmd_t           s1_data_reg;
    logic                 out_valid_reg;
    adcrr_rsp_t           out_data_reg;

    logic                 s1_adv;
    logic                 s1_fire;
    logic [MAX_CHANS-1:0] act_mask;
    logic [CHAN_W-1:0]    sel_from;
    logic                 sel_found;
    logic [CHAN_W-1:0]    sel_chan;
    logic [SAMPLE_W-1:0]  rd_data;
    adcrr_wr_t            store_wr;
    adcrr_rsp_t           res;

    // Handshake
    assign s1_adv    = !out_valid_reg || rsp_ready;
    assign s1_fire   = s1_valid_reg && s1_adv;
    assign cmd_ready = !s1_valid_reg || s1_adv;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    // Drop mask bits past the scan count
    assign act_mask = mask_reg & SCAN_LIM;

    // Start scans from channel zero, done moves past the current channel
    always_comb
    begin
        if (s1_data_reg.command == CMD_DONE)
        begin
            sel_from = (cur_reg == LAST_CHAN) ? '0 : cur_reg + CHAN_W'(1);
        end
        else
        begin
            sel_from = '0;
        end
    end

    adcrr_next_sel #(
        .SCAN_COUNT (SCAN_COUNT)
    ) u_next_sel (
        .mask  (act_mask),
        .from  (sel_from),
        .found (sel_found),
        .chan  (sel_chan)
    );

    adcrr_sample_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (store_wr),
        .rd_addr (s1_data_reg.read_channel),
        .rd_data (rd_data)
    );

    // Decode the registered command
    always_comb
    begin
        res           = '0;
        cur_next      = cur_reg;
        store_wr.en   = 1'b0;
        store_wr.addr = cur_reg;
        store_wr.data = s1_data_reg.sample_value;
        unique case (s1_data_reg.command)
            CMD_START:
            begin
                if (sel_found)
                begin
                    res.start_conversion = 1'b1;
                    res.convert_channel  = sel_chan;
                    cur_next             = sel_chan;
                end
            end
            CMD_DONE:
            begin
                if (act_mask != '0)
                begin
                    store_wr.en = s1_fire;
                    if (sel_found)
                    begin
                        res.start_conversion = 1'b1;
                        res.convert_channel  = sel_chan;
                        cur_next             = sel_chan;
                    end
                end
            end
            CMD_READ:
            begin
                if (act_mask[s1_data_reg.read_channel])
                begin
                    res.read_data = rd_data;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (cfg_we)
        begin
            mask_reg <= cfg_wdata;
        end
    end

    // Advance scan state and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                cur_reg <= cur_next;
            end
            if (cmd_ready)
            begin
                s1_valid_reg <= cmd_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            s1_data_reg <= cmd_data;
        end
        if (s1_fire)
        begin
            out_data_reg <= res;
        end
    end

    // Current channel always stays inside the scanned range
    a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cur_reg} < (CHAN_W+1)'(SCAN_COUNT))
        else $error("current channel out of scan range");

    // No conversion request means a zero channel field
    a_chan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !res.start_conversion |-> res.convert_channel == '0)
        else $error("channel set without conversion request");

    // Only read commands return sample data
    a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_data_reg.command != CMD_READ |-> res.read_data == '0)
        else $error("read data on a non-read command");

    // A start with any enabled channel must request a conversion
    a_start_issues: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_data_reg.command == CMD_START && act_mask != '0
        |-> res.start_conversion && act_mask[res.convert_channel])
        else $error("start did not pick an enabled channel");

endmodule
